>>> src/llm_pkg.sv
package llm_pkg;

  localparam int unsigned AccW = 31;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  typedef enum logic [2:0] {
    OP_ADD_COUNT   = 3'd0,
    OP_ADD_LATENCY = 3'd1,
    OP_ADD_SAMPLE  = 3'd2,
    OP_ADD_BATCH   = 3'd3,
    OP_QUERY       = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now_seconds;
    logic [15:0] latency_ms;
    logic [15:0] sample_count;
  } in_word_t;

  typedef struct packed {
    logic [28:0] recent_count;
    logic [30:0] avg_latency_ms;
    logic [30:0] peak_latency_ms;
    logic        overloaded;
  } out_word_t;

endpackage

>>> src/llm_div.sv
// Restoring divider, one quotient bit per cycle. 64-bit dividend, 48-bit divisor.
module llm_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [47:0]          divisor,
  output logic                 done,
  output logic [63:0]          quotient
);
  logic [6:0]  count;
  logic [48:0] rem;
  logic [63:0] quo;
  logic [48:0] trial;
  logic [47:0] dsr;
  logic        running;

  assign trial = {rem[47:0], quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= 7'd64;
        rem     <= '0;
        quo     <= dividend;
        dsr     <= divisor;
      end else if (running) begin
        if (!trial[48]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[47:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    running && count != 7'd1 |-> !start) else $error("divider restarted");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_count: assert property (@(posedge clk) disable iff (rst)
    running |-> count != 7'd0) else $error("count underflow");
`endif
endmodule

>>> src/load_latency_monitor.sv
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | llm_pkg::in_word_t
// out     | out | out_valid/out_ready| llm_pkg::out_word_t
// apb     | in  | psel/penable       | target registers at 0x0, 0x4
// One word at a time through one shared restoring divider. After acceptance a
// word passes a check state, one decay step per elapsed second (up to
// MAX_CATCHUP_SECONDS), an apply state, a batch peak division for a non-empty
// batch, then the average and peak divisions when latency events are held.
// Reset (rst, synchronous) clears accumulators, targets and control.
// in_ready is low from acceptance until the result word is taken; the next
// word can be accepted in the cycle after that.
module load_latency_monitor #(
  parameter int unsigned MAX_CATCHUP_SECONDS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  llm_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output llm_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int unsigned AW = llm_pkg::AccW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CHECK = 8'b00000010,
    S_DECAY = 8'b00000100,
    S_APPLY = 8'b00001000,
    S_PKDIV = 8'b00010000,
    S_AVDIV = 8'b00100000,
    S_PDIV  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  logic [31:0] target_avg, target_peak;
  logic [31:0] last_second;
  logic [AW-1:0] ev, lev, lsum, lpeak;
  llm_pkg::in_word_t cur;
  logic [31:0] avg_q;
  logic [15:0] lat_eff;

  // shared divider
  logic        dstart;
  logic [63:0] dividend, quotient;
  logic [47:0] divisor;
  logic        ddone;

  llm_div u_div (.clk, .rst, .start(dstart), .dividend, .divisor, .done(ddone), .quotient);

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      1'b0: prdata = target_avg;
      1'b1: prdata = target_peak;
      default: prdata = '0;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // saturating add
  function automatic logic [AW-1:0] sat(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {2'b00, llm_pkg::AccMax}) ? llm_pkg::AccMax : s[AW-1:0];
  endfunction

  // clamp a product/quotient to accumulator range
  function automatic logic [AW-1:0] clamp(input logic [63:0] v);
    return (v > {33'd0, llm_pkg::AccMax}) ? llm_pkg::AccMax : v[AW-1:0];
  endfunction

  logic [32:0] limit;
  assign limit = {1'b0, last_second} + 33'(MAX_CATCHUP_SECONDS);
  assign lat_eff = (cur.latency_ms == 16'd1) ? 16'd0 : cur.latency_ms;

  // two multipliers: updated lev * latency, 31x16; the x4 comes from a later shift
  logic [AW-1:0] lev_single, lev_batch;
  logic [46:0]   pk_single, pk_batch;
  assign lev_single = sat(lev, 32'd1);
  assign lev_batch  = sat(lev, {16'd0, cur.sample_count});
  assign pk_single  = lev_single * lat_eff;
  assign pk_batch   = lev_batch * cur.latency_ms;

  // a non-empty batch needs its peak division before the averages
  logic pk_pending;
  assign pk_pending = (cur.operation == llm_pkg::OP_ADD_BATCH) && (cur.sample_count != '0);

  always_comb begin
    dstart   = 1'b0;
    dividend = '0;
    divisor  = {17'd0, lev} << 2;
    unique case (state)
      S_APPLY: begin
        dstart   = pk_pending;
        dividend = {15'd0, pk_batch, 2'b00};
        divisor  = {32'd0, cur.sample_count};
      end
      S_PKDIV: begin
        // average division starts as the peak stage ends
        dstart   = (ddone || !pk_pending) && (lev != '0);
        dividend = {33'd0, lsum};
      end
      S_AVDIV: begin
        dstart   = ddone;
        dividend = {33'd0, lpeak};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      target_avg <= '0;
      target_peak <= '0;
      last_second <= '0;
      ev <= '0; lev <= '0; lsum <= '0; lpeak <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2]) target_peak <= pwdata;
        else target_avg <= pwdata;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          cur <= in_data;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cur.now_seconds == last_second) state <= S_APPLY;
          else if (cur.now_seconds < last_second || {1'b0, cur.now_seconds} > limit) begin
            ev <= '0; lev <= '0; lsum <= '0; lpeak <= '0;
            last_second <= cur.now_seconds;
            state <= S_APPLY;
          end else state <= S_DECAY;
        end
        S_DECAY: begin
          // one second of decay per cycle
          last_second <= last_second + 32'd1;
          ev    <= ev - AW'(({1'b0, ev} + 32'd3) >> 2);
          lev   <= lev - AW'(({1'b0, lev} + 32'd3) >> 2);
          lsum  <= lsum - (lsum >> 2);
          lpeak <= lpeak - (lpeak >> 2);
          if (last_second + 32'd1 == cur.now_seconds) state <= S_APPLY;
        end
        S_APPLY: begin
          case (cur.operation) inside
            llm_pkg::OP_ADD_COUNT: ev <= sat(ev, 32'd1);
            llm_pkg::OP_ADD_LATENCY, llm_pkg::OP_ADD_SAMPLE: begin
              if (cur.operation == llm_pkg::OP_ADD_SAMPLE) ev <= sat(ev, 32'd1);
              lev  <= lev_single;
              lsum <= sat(lsum, {16'd0, lat_eff});
              begin
                logic [AW-1:0] np, cand;
                np = sat(lpeak, {16'd0, lat_eff});
                cand = clamp({15'd0, pk_single, 2'b00});
                lpeak <= (cand > np) ? cand : np;
              end
            end
            llm_pkg::OP_ADD_BATCH: begin
              ev   <= sat(ev, {16'd0, cur.sample_count});
              lev  <= lev_batch;
              lsum <= sat(lsum, {16'd0, cur.latency_ms});
              lpeak <= sat(lpeak, {16'd0, cur.latency_ms});
            end
            default: ;
          endcase
          state <= S_PKDIV;
        end
        S_PKDIV: begin
          // wait for batch peak division if one was started
          if (ddone) begin
            if (clamp(quotient) > lpeak) lpeak <= clamp(quotient);
          end
          if (ddone || !pk_pending) begin
            state <= (lev == '0) ? S_OUT : S_AVDIV;
          end
        end
        S_AVDIV: if (ddone) begin
          avg_q <= 32'(quotient);
          state <= S_PDIV;
        end
        S_PDIV: if (ddone) state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [31:0] peak_r;
  logic        res_ok;
  always_ff @(posedge clk) begin
    if (state == S_PDIV && ddone) peak_r <= 32'(quotient);
  end
  assign res_ok = (lev != '0);
  logic [31:0] avg_v, peak_v;
  assign avg_v  = res_ok ? avg_q : 32'd0;
  assign peak_v = res_ok ? peak_r : 32'd0;

  assign out_data.recent_count    = ev[AW-1:2];
  assign out_data.avg_latency_ms  = avg_v[30:0];
  assign out_data.peak_latency_ms = peak_v[30:0];
  assign out_data.overloaded = (target_peak != '0 && peak_v > target_peak) ||
                               (target_avg != '0 && avg_v > target_avg);

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> last_second == cur.now_seconds) else $error("time not settled");
`endif
endmodule
